>>> hdl/ucs_pkg.sv
// shared widths, codes and types for the cpu utilization window statistics block
`timescale 1ns / 1ps
`default_nettype none
package ucs_pkg;

    localparam int TICK_W      = 31;
    localparam int TOTAL_W     = 35;
    localparam int USAGE_W     = 14;
    localparam int CNT_W       = 11;
    localparam int ACC_W       = 24;
    localparam int NUM_FIELDS  = 10;
    localparam int FIELD_IDX_W = 4;
    localparam int IDLE_FIELD  = 3;
    localparam int MAX_WINDOW  = 1024;
    localparam int Q_BITS      = 14;
    localparam int DIV_W       = TOTAL_W + Q_BITS;
    localparam int DCNT_W      = 4;

    localparam logic [USAGE_W-1:0] FULL_SCALE   = USAGE_W'(10000);
    localparam logic [CNT_W-1:0]   CFG_RESET    = CNT_W'(60);
    localparam logic [CNT_W-1:0]   MAX_WIN_CODE = CNT_W'(MAX_WINDOW);

    // usage class decided by the front part
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TOTAL_W-1:0] busy;
        logic [TOTAL_W-1:0] dtotal;
    } ucs_job_t;

endpackage
`default_nettype wire

>>> hdl/ucs_snap_if.sv
// snapshot channel: valid, ready and the ten counters
`timescale 1ns / 1ps
`default_nettype none
interface ucs_snap_if;
    import ucs_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] user_ticks;
    logic [TICK_W-1:0] nice_ticks;
    logic [TICK_W-1:0] system_ticks;
    logic [TICK_W-1:0] idle_ticks;
    logic [TICK_W-1:0] iowait_ticks;
    logic [TICK_W-1:0] irq_ticks;
    logic [TICK_W-1:0] softirq_ticks;
    logic [TICK_W-1:0] steal_ticks;
    logic [TICK_W-1:0] guest_ticks;
    logic [TICK_W-1:0] guest_lowpri_ticks;

    modport source (
        output valid, user_ticks, nice_ticks, system_ticks, idle_ticks, iowait_ticks,
               irq_ticks, softirq_ticks, steal_ticks, guest_ticks, guest_lowpri_ticks,
        input  ready
    );
    modport sink (
        input  valid, user_ticks, nice_ticks, system_ticks, idle_ticks, iowait_ticks,
               irq_ticks, softirq_ticks, steal_ticks, guest_ticks, guest_lowpri_ticks,
        output ready
    );
endinterface
`default_nettype wire

>>> hdl/ucs_stats_if.sv
// window result channel: valid, ready, min, mean and max usage
`timescale 1ns / 1ps
`default_nettype none
interface ucs_stats_if;
    import ucs_pkg::*;

    logic               valid;
    logic               ready;
    logic [USAGE_W-1:0] min_usage;
    logic [USAGE_W-1:0] mean_usage;
    logic [USAGE_W-1:0] max_usage;

    modport source (output valid, min_usage, mean_usage, max_usage, input ready);
    modport sink (input valid, min_usage, mean_usage, max_usage, output ready);
endinterface
`default_nettype wire

>>> hdl/ucs_front.sv
// front part: takes a snapshot, sums the counters, forms deltas and classifies
`timescale 1ns / 1ps
`default_nettype none
module ucs_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ucs_snap_if.sink              snap,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output ucs_pkg::ucs_job_t     push_data
);
    import ucs_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_SUM   = 2'd1;
    localparam logic [1:0] F_DIFF  = 2'd2;
    localparam logic [1:0] F_CLASS = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [TICK_W-1:0]      tick_reg [NUM_FIELDS];
    logic [FIELD_IDX_W-1:0] idx_reg, idx_next;
    logic [TOTAL_W-1:0]     sum_reg, sum_next;
    logic [TOTAL_W-1:0]     prev_total_reg, prev_total_next;
    logic [TICK_W-1:0]      prev_idle_reg, prev_idle_next;
    logic [TOTAL_W:0]       dtotal_reg, dtotal_next;
    logic [TICK_W:0]        didle_reg, didle_next;

    logic                   accept;
    logic [TOTAL_W+1:0]     busy;
    logic                   dt_pos, busy_pos, didle_pos;

    assign snap.ready = (state_reg == F_IDLE);
    assign accept     = snap.valid && snap.ready;

    // busy = dtotal - didle, both sign extended
    assign busy      = {dtotal_reg[TOTAL_W], dtotal_reg}
                     - {{(TOTAL_W - TICK_W + 1){didle_reg[TICK_W]}}, didle_reg};
    assign dt_pos    = !dtotal_reg[TOTAL_W] && (dtotal_reg != '0);
    assign busy_pos  = !busy[TOTAL_W+1] && (busy != '0);
    assign didle_pos = !didle_reg[TICK_W] && (didle_reg != '0);

    always_comb
    begin
        push_data.busy   = busy[TOTAL_W-1:0];
        push_data.dtotal = dtotal_reg[TOTAL_W-1:0];
        if (!dt_pos || !busy_pos)
        begin
            push_data.kind = KIND_ZERO;
        end
        else if (!didle_pos)
        begin
            push_data.kind = KIND_FULL;
        end
        else
        begin
            push_data.kind = KIND_DIV;
        end
    end

    assign push_valid = (state_reg == F_CLASS);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        prev_total_next = prev_total_reg;
        prev_idle_next  = prev_idle_reg;
        dtotal_next     = dtotal_reg;
        didle_next      = didle_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                sum_next = sum_reg + TOTAL_W'(tick_reg[idx_reg]);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FIELD_IDX_W'(NUM_FIELDS - 1))
                begin
                    state_next = F_DIFF;
                end
            end
            F_DIFF:
            begin
                dtotal_next     = {1'b0, sum_reg} - {1'b0, prev_total_reg};
                didle_next      = {1'b0, tick_reg[IDLE_FIELD]} - {1'b0, prev_idle_reg};
                prev_total_next = sum_reg;
                prev_idle_next  = tick_reg[IDLE_FIELD];
                state_next      = F_CLASS;
            end
            F_CLASS:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            prev_total_reg <= '0;
            prev_idle_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_total_reg <= prev_total_next;
            prev_idle_reg  <= prev_idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        dtotal_reg <= dtotal_next;
        didle_reg  <= didle_next;
        if (accept)
        begin
            tick_reg[0] <= snap.user_ticks;
            tick_reg[1] <= snap.nice_ticks;
            tick_reg[2] <= snap.system_ticks;
            tick_reg[3] <= snap.idle_ticks;
            tick_reg[4] <= snap.iowait_ticks;
            tick_reg[5] <= snap.irq_ticks;
            tick_reg[6] <= snap.softirq_ticks;
            tick_reg[7] <= snap.steal_ticks;
            tick_reg[8] <= snap.guest_ticks;
            tick_reg[9] <= snap.guest_lowpri_ticks;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ucs_fifo.sv
// two-entry job queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module ucs_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ucs_pkg::ucs_job_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ucs_pkg::ucs_job_t      pop_data
);
    import ucs_pkg::*;

    ucs_job_t   entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ucs_back.sv
// back part: serial usage divide, window trackers, mean divide, result register
`timescale 1ns / 1ps
`default_nettype none
module ucs_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pop_valid,
    output logic                           pop_ready,
    input  wire ucs_pkg::ucs_job_t         pop_data,
    input  wire logic [ucs_pkg::CNT_W-1:0] win_len,
    ucs_stats_if.source                    stats
);
    import ucs_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_UPD  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [TOTAL_W-1:0] busy_reg, dtotal_reg;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvsr_reg, dvsr_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [USAGE_W-1:0] q_reg, q_next;
    logic               mean_mode_reg, mean_mode_next;

    logic [USAGE_W-1:0] win_min_reg, win_min_next;
    logic [USAGE_W-1:0] win_max_reg, win_max_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [USAGE_W-1:0] res_min_reg, res_min_next;
    logic [USAGE_W-1:0] res_max_reg, res_max_next;

    logic               out_valid_reg, out_valid_next;
    logic [USAGE_W-1:0] out_min_reg, out_mean_reg, out_max_reg;
    logic               out_load;

    logic [USAGE_W-1:0] upd_min, upd_max;
    logic [ACC_W-1:0]   upd_acc;
    logic [CNT_W-1:0]   upd_count;
    logic               step_ge;

    assign pop_ready = (state_reg == B_IDLE);

    assign stats.valid      = out_valid_reg;
    assign stats.min_usage  = out_min_reg;
    assign stats.mean_usage = out_mean_reg;
    assign stats.max_usage  = out_max_reg;

    assign upd_min   = (q_reg < win_min_reg) ? q_reg : win_min_reg;
    assign upd_max   = (q_reg > win_max_reg) ? q_reg : win_max_reg;
    assign upd_acc   = acc_reg + ACC_W'(q_reg);
    assign upd_count = count_reg + 1'b1;
    assign step_ge   = (rem_reg >= dvsr_reg);
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || stats.ready);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dvsr_next      = dvsr_reg;
        dcnt_next      = dcnt_reg;
        q_next         = q_reg;
        mean_mode_next = mean_mode_reg;
        win_min_next   = win_min_reg;
        win_max_next   = win_max_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        res_min_next   = res_min_reg;
        res_max_next   = res_max_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && stats.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_data.kind)
                        KIND_DIV:
                        begin
                            state_next = B_MUL;
                        end
                        KIND_FULL:
                        begin
                            q_next     = FULL_SCALE;
                            state_next = B_UPD;
                        end
                        default:
                        begin
                            q_next     = '0;
                            state_next = B_UPD;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                // quotient stays below full scale, so fourteen bits suffice
                rem_next       = DIV_W'(busy_reg) * DIV_W'(FULL_SCALE);
                dvsr_next      = DIV_W'(dtotal_reg) << (Q_BITS - 1);
                dcnt_next      = DCNT_W'(Q_BITS - 1);
                q_next         = '0;
                mean_mode_next = 1'b0;
                state_next     = B_DIV;
            end
            B_DIV:
            begin
                if (step_ge)
                begin
                    rem_next = rem_reg - dvsr_reg;
                end
                q_next    = {q_reg[USAGE_W-2:0], step_ge};
                dvsr_next = dvsr_reg >> 1;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    state_next = mean_mode_reg ? B_OUT : B_UPD;
                end
            end
            B_UPD:
            begin
                if (upd_count >= win_len)
                begin
                    // window closes: keep min and max, divide the sum, clear trackers
                    res_min_next   = upd_min;
                    res_max_next   = upd_max;
                    rem_next       = DIV_W'(upd_acc);
                    dvsr_next      = DIV_W'(upd_count) << (Q_BITS - 1);
                    dcnt_next      = DCNT_W'(Q_BITS - 1);
                    q_next         = '0;
                    mean_mode_next = 1'b1;
                    win_min_next   = FULL_SCALE;
                    win_max_next   = '0;
                    acc_next       = '0;
                    count_next     = '0;
                    state_next     = B_DIV;
                end
                else
                begin
                    win_min_next = upd_min;
                    win_max_next = upd_max;
                    acc_next     = upd_acc;
                    count_next   = upd_count;
                    state_next   = B_IDLE;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            mean_mode_reg <= 1'b0;
            win_min_reg   <= FULL_SCALE;
            win_max_reg   <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mean_mode_reg <= mean_mode_next;
            win_min_reg   <= win_min_next;
            win_max_reg   <= win_max_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dvsr_reg    <= dvsr_next;
        dcnt_reg    <= dcnt_next;
        q_reg       <= q_next;
        res_min_reg <= res_min_next;
        res_max_reg <= res_max_next;
        if (pop_valid && pop_ready)
        begin
            busy_reg   <= pop_data.busy;
            dtotal_reg <= pop_data.dtotal;
        end
        if (out_load)
        begin
            out_min_reg  <= res_min_reg;
            out_mean_reg <= q_reg;
            out_max_reg  <= res_max_reg;
        end
    end

    // usage from either path never exceeds full scale
    a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_UPD |-> q_reg <= FULL_SCALE)
        else $error("usage above full scale");

    // window count never runs past the largest window
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < MAX_WIN_CODE)
        else $error("window count overflow");

    // a fresh result has its mean between min and max
    a_mean_order: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_load) |-> (out_min_reg <= out_mean_reg) && (out_mean_reg <= out_max_reg))
        else $error("mean outside min and max");

endmodule
`default_nettype wire

>>> hdl/cpu_utilization_window_stats.sv
// top level of the cpu utilization window statistics block
// a window-closing item goes through the front, the queue, the usage divide and the update,
//   then the mean divide and the output register before the result valid rises
// the back part takes a new item only in its idle state; items classed for division use its
//   14-step serial divider, and a window-closing item also holds it for the mean divide
// reset: asynchronous, clears previous counts and window trackers, window length 60
`timescale 1ns / 1ps
`default_nettype none
module cpu_utilization_window_stats (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    ucs_snap_if.sink                       snap,
    ucs_stats_if.source                    stats,
    input  wire logic                      cfg_we,
    input  wire logic [ucs_pkg::CNT_W-1:0] cfg_wdata
);
    import ucs_pkg::*;

    // window length register and its clamped form
    logic [CNT_W-1:0] cfg_reg;
    logic [CNT_W-1:0] win_len;

    // queue between front and back parts
    logic     push_valid, push_ready;
    ucs_job_t push_data;
    logic     pop_valid, pop_ready;
    ucs_job_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // zero counts as one sample, anything above the largest window saturates
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (cfg_reg > MAX_WIN_CODE)
        begin
            win_len = MAX_WIN_CODE;
        end
        else
        begin
            win_len = cfg_reg;
        end
    end

    // front: accept, sum the ten counters, take deltas, classify usage
    ucs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so the front can take the next snapshot while the back divides
    ucs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: usage divide, window min, max and sum, mean divide, result register
    ucs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .win_len   (win_len),
        .stats     (stats)
    );

endmodule
`default_nettype wire
